// File: hw/rtl/sft_pkg.sv
// ----------------------------------------------------------------------------
// sft_pkg: shared types and constants of the stuffed frame transmitter
// Command codes, wire constants, queue entry layout and back-end phases.
// ----------------------------------------------------------------------------
package sft_pkg;

    // Item command codes
    localparam logic CMD_HDR = 1'b0;
    localparam logic CMD_PAY = 1'b1;

    // Wire constants
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_FLAG  = 8'h5E;
    localparam logic [7:0] ESC_ESC   = 8'h5D;

    // Header layout: seven bytes, low byte first
    localparam int HDR_BYTES  = 7;
    localparam int HDR_IDX_W  = 3;
    localparam int HDR_DATA_W = HDR_BYTES * 8;
    localparam logic [HDR_IDX_W-1:0] LAST_HDR_IDX = HDR_IDX_W'(HDR_BYTES - 1);

    // Kind of work handed from front to back
    typedef enum logic [1:0] {
        K_HDR,
        K_PAY,
        K_STRAY
    } t_kind;

    // One queue entry: a classified request
    typedef struct packed {
        t_kind                  kind;
        logic                   err_first;
        logic                   close;
        logic [HDR_DATA_W-1:0]  data;
    } t_op;

    // Back-end emission phases
    typedef enum logic [1:0] {
        PH_ERR,
        PH_DATA,
        PH_SUM,
        PH_FLAG
    } t_phase;

endpackage

// File: hw/rtl/sft_ifs.sv
// ----------------------------------------------------------------------------
// sft_ifs: channel interfaces of the stuffed frame transmitter
// Item channel into the block and wire byte channel out of it.
// ----------------------------------------------------------------------------
interface sft_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] app_id;
    logic [15:0] message_id;
    logic [7:0]  ack_status;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;

    modport source (
        output valid, cmd, app_id, message_id, ack_status, payload_length, payload_byte,
        input  ready
    );
    modport sink (
        input  valid, cmd, app_id, message_id, ack_status, payload_length, payload_byte,
        output ready
    );
endinterface

interface sft_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       end_of_frame;
    logic       protocol_error;
    logic       last_of_run;

    modport source (
        output valid, tx_byte, end_of_frame, protocol_error, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, tx_byte, end_of_frame, protocol_error, last_of_run,
        output ready
    );
endinterface

// File: hw/rtl/sft_front.sv
// ----------------------------------------------------------------------------
// sft_front: item classifier
// Accepts header and payload requests, tracks the open frame and the bytes
// still owed, and pushes one classified entry per request into the queue.
// ----------------------------------------------------------------------------
module sft_front import sft_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sft_in_if.sink   i_in,
    input  logic     i_full,
    output logic     o_push,
    output t_op      o_op
);

    logic [15:0] r_owed, n_owed;
    logic        r_open, n_open;
    logic        accept;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign o_push     = accept;

    // Classify the request and work out the frame state it leaves
    always_comb begin
        n_owed      = r_owed;
        n_open      = r_open;
        o_op.kind   = K_STRAY;
        o_op.err_first = 1'b0;
        o_op.close  = 1'b0;
        o_op.data   = {i_in.payload_length, i_in.ack_status, i_in.message_id, i_in.app_id};
        if (i_in.cmd == CMD_HDR) begin
            o_op.kind      = K_HDR;
            o_op.err_first = r_open && (r_owed != 16'd0);
            o_op.close     = (i_in.payload_length == 16'd0);
            n_owed         = i_in.payload_length;
            n_open         = (i_in.payload_length != 16'd0);
        end else begin
            o_op.data = {{(HDR_DATA_W - 8){1'b0}}, i_in.payload_byte};
            if (r_open && (r_owed != 16'd0)) begin
                o_op.kind  = K_PAY;
                o_op.close = (r_owed == 16'd1);
                n_owed     = r_owed - 16'd1;
                n_open     = (r_owed != 16'd1);
            end
        end
    end

    // Hold frame state, advance it on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owed <= '0;
            r_open <= 1'b0;
        end else if (accept) begin
            r_owed <= n_owed;
            r_open <= n_open;
        end
    end

endmodule

// File: hw/rtl/sft_fifo.sv
// ----------------------------------------------------------------------------
// sft_fifo: short request queue
// Register-based FIFO between the classifier and the byte emitter.
// ----------------------------------------------------------------------------
module sft_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/sft_back.sv
// ----------------------------------------------------------------------------
// sft_back: byte emitter
// Expands the queue head into escaped wire bytes: error marker, header or
// payload bytes, checksum and closing flag, one byte per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module sft_back import sft_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_op       i_op,
    output logic      o_pop,
    sft_out_if.source o_out
);

    t_phase                r_phase, n_phase, cur_phase;
    logic                  r_started;
    logic [HDR_IDX_W-1:0]  r_idx, n_idx, cur_idx;
    logic                  r_esc2;
    logic [7:0]            r_sum, n_sum;
    logic                  emit;
    logic [7:0]            raw;
    logic                  need_esc;
    logic                  byte_done;
    logic                  op_done;
    logic [7:0]            wire_byte;
    logic                  is_err;
    logic                  is_eof;

    logic                  r_out_valid;
    logic [7:0]            r_out_byte;
    logic                  r_out_eof;
    logic                  r_out_err;
    logic                  r_out_last;

    assign emit = i_valid && (!r_out_valid || o_out.ready);

    // Pick the phase and byte index of the current request
    always_comb begin
        if (r_started) begin
            cur_phase = r_phase;
            cur_idx   = r_idx;
        end else begin
            cur_phase = ((i_op.kind == K_STRAY) || i_op.err_first) ? PH_ERR : PH_DATA;
            cur_idx   = '0;
        end
    end

    // Select the raw byte and escape it
    always_comb begin
        raw = (cur_phase == PH_SUM) ? r_sum : 8'(i_op.data >> {cur_idx, 3'b000});
        need_esc = ((cur_phase == PH_DATA) || (cur_phase == PH_SUM))
                   && ((raw == FLAG_BYTE) || (raw == ESC_BYTE));
        byte_done = !need_esc || r_esc2;
        if (r_esc2) begin
            wire_byte = (raw == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
        end else if (need_esc) begin
            wire_byte = ESC_BYTE;
        end else begin
            wire_byte = raw;
        end
    end

    // Sequence the phases of one request
    always_comb begin
        n_phase = cur_phase;
        n_idx   = cur_idx;
        op_done = 1'b0;
        is_err  = 1'b0;
        is_eof  = 1'b0;
        unique case (cur_phase)
            PH_ERR: begin
                is_err = 1'b1;
                if (i_op.kind == K_STRAY) begin
                    op_done = 1'b1;
                end else begin
                    n_phase = PH_DATA;
                    n_idx   = '0;
                end
            end
            PH_DATA: begin
                if (byte_done) begin
                    if ((i_op.kind == K_HDR) && (cur_idx != LAST_HDR_IDX)) begin
                        n_idx = cur_idx + 1'b1;
                    end else if (i_op.close) begin
                        n_phase = PH_SUM;
                    end else begin
                        op_done = 1'b1;
                    end
                end
            end
            PH_SUM: begin
                if (byte_done) begin
                    n_phase = PH_FLAG;
                end
            end
            PH_FLAG: begin
                is_eof  = 1'b1;
                op_done = 1'b1;
            end
            default: begin
                op_done = 1'b1;
            end
        endcase
    end

    // Add each frame byte once; restart at a header, clear after the flag
    always_comb begin
        n_sum = r_sum;
        if ((cur_phase == PH_DATA) && !r_esc2) begin
            n_sum = (((i_op.kind == K_HDR) && (cur_idx == '0)) ? 8'd0 : r_sum) + raw;
        end else if (cur_phase == PH_FLAG) begin
            n_sum = 8'd0;
        end
    end

    assign o_pop = emit && op_done;

    // Hold sequencer state, advance on each emitted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_DATA;
            r_started <= 1'b0;
            r_idx     <= '0;
            r_esc2    <= 1'b0;
            r_sum     <= '0;
        end else if (emit) begin
            r_phase   <= n_phase;
            r_started <= !op_done;
            r_idx     <= n_idx;
            r_esc2    <= need_esc && !r_esc2;
            r_sum     <= n_sum;
        end
    end

    // Output register: load on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= is_err ? 8'd0 : (is_eof ? FLAG_BYTE : wire_byte);
            r_out_eof  <= is_eof;
            r_out_err  <= is_err;
            r_out_last <= op_done;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.tx_byte        = r_out_byte;
    assign o_out.end_of_frame   = r_out_eof;
    assign o_out.protocol_error = r_out_err;
    assign o_out.last_of_run    = r_out_last;

endmodule

// File: hw/rtl/stuffed_frame_transmitter_top.sv
// ----------------------------------------------------------------------------
// stuffed_frame_transmitter_top: byte-stuffing frame transmitter
// Turns header and payload requests into escaped wire bytes with an
// additive checksum and a closing flag.
//
//   Port     Dir   Handshake     Carries
//   i_in     in    valid/ready   cmd, app_id, message_id, ack_status,
//                                payload_length, payload_byte
//   o_out    out   valid/ready   tx_byte, end_of_frame, protocol_error,
//                                last_of_run
//
// The emitter puts out one wire byte per cycle unless the output stalls: a
// payload request gives its byte, escaped if need be, plus checksum and flag
// when it closes the frame; a header gives its seven bytes. The classifier
// takes one request per cycle until the QUEUE_DEPTH-entry queue fills. Reset
// is synchronous and needs no clearing pass. A stalled output holds its byte
// and the emitter waits; the input keeps flowing until the queue is full.
// ----------------------------------------------------------------------------
module stuffed_frame_transmitter_top import sft_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sft_in_if.sink    i_in,
    sft_out_if.source o_out
);

    localparam int OP_W = $bits(t_op);

    t_op             front_op;
    t_op             head_op;
    logic            push;
    logic            full;
    logic            pop;
    logic            head_valid;
    logic [OP_W-1:0] head_bits;

    // Classify requests
    sft_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_op    (front_op)
    );

    // Decouple classifier from emitter
    sft_fifo #(
        .WIDTH (OP_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_op),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_bits),
        .o_valid (head_valid)
    );

    assign head_op = t_op'(head_bits);

    // Emit wire bytes
    sft_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_op    (head_op),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
